// File: hw/rtl/mmpd_pkg.sv
// ----------------------------------------------------------------------------
// mmpd_pkg
// Shared constants, codes and handshake types of the multi-motor PD command
// block.
// ----------------------------------------------------------------------------
package mmpd_pkg;

	// default motor count of the top level
	localparam int MOTORS_DEF = 8;

	// payload widths
	localparam int IDX_W  = 3;
	localparam int MODE_W = 2;
	localparam int Q_W    = 32;

	// requested modes
	localparam logic [MODE_W-1:0] MODE_OPEN     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BRAKE    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CURRENT  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_POSITION = 2'd3;

	// drive modes of a command
	localparam logic [MODE_W-1:0] DRV_OPEN    = 2'd0;
	localparam logic [MODE_W-1:0] DRV_BRAKE   = 2'd1;
	localparam logic [MODE_W-1:0] DRV_CURRENT = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_KP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KD = 1'b1;

	// timestamp rate in ticks per second
	localparam logic [Q_W-1:0] TICK_RATE = 32'd180_000_000;

	// velocity divider: |dpos| * TICK_RATE stays below 2^60
	localparam int DVD_W     = 60;
	localparam int DIVR_W    = 32;
	localparam int DIV_STEPS = DVD_W;

	// derivative term magnitude cap
	localparam int DMAG_W = 61;
	localparam logic [DMAG_W-1:0] D_CAP = 61'h1000_0000_0000_0000;

	// saturation limits of the command current
	localparam logic [Q_W-1:0] CUR_MAX = 32'h7fff_ffff;
	localparam logic [Q_W-1:0] CUR_MIN = 32'h8000_0000;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: hw/rtl/mmpd_divider.sv
// ----------------------------------------------------------------------------
// mmpd_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmpd_divider
	import mmpd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] divisor_q;
	logic [DVD_W-1:0]  dvd_q;

	logic [DIVR_W:0]   shifted;
	logic [DIVR_W+1:0] trial;

	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			dvd_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			// keep the trial remainder when it did not go negative
			if (!trial[DIVR_W+1]) begin
				rem_q <= trial[DIVR_W-1:0];
			end else begin
				rem_q <= shifted[DIVR_W-1:0];
			end
			dvd_q <= {dvd_q[DVD_W-2:0], ~trial[DIVR_W+1]};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.quotient = dvd_q;

endmodule

// File: hw/rtl/multi_motor_pd_command.sv
// ----------------------------------------------------------------------------
// multi_motor_pd_command
// Per-motor drive command generator with a Q16.16 PD position loop.
// ----------------------------------------------------------------------------
// Usage:
// - The slave stream carries one motor status per request; s_tlast marks the
//   last status of a batch. The master stream returns one command per status,
//   tagged with the batch counter value seen when the status was taken.
// - Open and brake requests give zero current; current requests pass the
//   desired current through; position requests add kp * error minus
//   kd * velocity, velocity = dpos * 180e6 / dticks, saturated to 32 bits.
// - Gains are written on the cfg port (index 0 kp, index 1 kd) while idle.
// - Open, brake, current and out-of-range requests go from the accept to the
//   output step and on into the output register; position requests first run
//   the 60-step serial velocity divider, four passes through the single shared
//   32x32 multiplier and the difference, add, cap and subtract steps. A new
//   request is taken only once the sequencer is back in idle.
// - s_tready is high only while the sequencer is idle. The result sits in an
//   output register; when the receiver stalls, a new request is still taken,
//   and its result holds in the final step until the register frees up.
// - Reset clears the gains, the batch counter and the per-motor history
//   (through per-motor valid bits, so no clearing pass is needed).
// ----------------------------------------------------------------------------
module multi_motor_pd_command
	import mmpd_pkg::*;
#(
	parameter int MOTORS = MOTORS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [Q_W-1:0]       cfg_data,
	// status requests
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [31:0] position_target, [63:32] current_target,
	// [95:64] position_now, [127:96] timestamp_ticks
	input  logic [127:0]         s_tdata,
	// [2:0] motor_index, [4:3] desired_mode
	input  logic [4:0]           s_tuser,
	input  logic                 s_tlast,
	// command requests
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [31:0] batch_number, [63:32] current_command
	output logic [63:0]          m_tdata,
	// [2:0] motor_number, [4:3] drive_mode
	output logic [4:0]           m_tuser
);

	localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

	// sequencer codes
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIFF = 4'd1;
	localparam logic [3:0] S_MULV = 4'd2;
	localparam logic [3:0] S_MULP = 4'd3;
	localparam logic [3:0] S_PADD = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_MULL = 4'd6;
	localparam logic [3:0] S_MULH = 4'd7;
	localparam logic [3:0] S_DCAP = 4'd8;
	localparam logic [3:0] S_DSUB = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	logic [3:0] state_q;

	// configuration and control state
	logic [Q_W-1:0] kp_q;
	logic [Q_W-1:0] kd_q;
	logic [Q_W-1:0] batch_cnt_q;
	logic           vld_q [MOTORS];
	logic           out_vld_q;

	// per-motor history
	logic [Q_W-1:0] pos_mem  [MOTORS];
	logic [Q_W-1:0] tick_mem [MOTORS];

	// captured request
	logic [IDX_W-1:0]  idx_q;
	logic [AW-1:0]     addr_q;
	logic [Q_W-1:0]    ptgt_q;
	logic [Q_W-1:0]    pnow_q;
	logic [Q_W-1:0]    ticks_q;
	logic [Q_W-1:0]    ctgt_q;
	logic [Q_W-1:0]    batch_q;
	logic [MODE_W-1:0] drive_q;
	logic [Q_W-1:0]    prev_pos_q;
	logic [Q_W-1:0]    prev_tick_q;
	logic              prev_vld_q;

	// working registers
	logic              err_neg_q;
	logic [Q_W-1:0]    err_mag_q;
	logic [Q_W-1:0]    dpos_mag_q;
	logic [Q_W-1:0]    dt_mag_q;
	logic              dt_zero_q;
	logic              vel_neg_q;
	logic [DVD_W-1:0]  vel_q;
	logic [63:0]       prod_q;
	logic [63:0]       lo_q;
	logic [DMAG_W-1:0] dmag_q;
	logic [63:0]       acc_q;

	// output payload
	logic [IDX_W-1:0]  out_idx_q;
	logic [Q_W-1:0]    out_batch_q;
	logic [MODE_W-1:0] out_drive_q;
	logic [Q_W-1:0]    out_cur_q;

	logic              s_acc;
	logic              out_load;
	logic [IDX_W-1:0]  in_idx;
	logic [MODE_W-1:0] in_mode;
	logic [AW-1:0]     in_addr;
	logic              in_rng;
	logic [31:0]       in_idx_ext;

	logic [Q_W-1:0]    prev_pos;
	logic [Q_W-1:0]    prev_tick;
	logic [Q_W:0]      err_w;
	logic [Q_W:0]      dpos_w;
	logic [Q_W-1:0]    dt_w;
	logic [Q_W:0]      err_abs;
	logic [Q_W:0]      dpos_abs;
	logic [Q_W-1:0]    dt_abs;

	logic [Q_W-1:0]    mul_a;
	logic [Q_W-1:0]    mul_b;

	logic [63:0]       ctgt_ext;
	logic [63:0]       p_ext;
	logic [63:0]       d_ext;
	logic [DMAG_W-1:0] d_sum;
	logic              acc_fits;
	logic [Q_W-1:0]    cur_sat;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// --------------------------------------------------------------------
	// request decode
	// --------------------------------------------------------------------
	assign in_idx     = s_tuser[2:0];
	assign in_mode    = s_tuser[4:3];
	assign in_idx_ext = 32'(in_idx);
	assign in_addr    = in_idx_ext[AW-1:0];
	assign in_rng     = (in_idx_ext < 32'(MOTORS));

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// the result may leave once the output register is empty or draining
	assign out_load = (state_q == S_OUT) && (!out_vld_q || m_tready);

	// --------------------------------------------------------------------
	// sequencer
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						// only an in-range position request runs the loop
						if (in_rng && in_mode == MODE_POSITION) begin
							state_q <= S_DIFF;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_DIFF: state_q <= S_MULV;
				S_MULV: state_q <= S_MULP;
				S_MULP: state_q <= S_PADD;
				S_PADD: state_q <= S_DIV;
				S_DIV: begin
					// hold until the velocity quotient is settled
					if (!div_rsp.busy) begin
						state_q <= S_MULL;
					end
				end
				S_MULL: state_q <= S_MULH;
				S_MULH: state_q <= S_DCAP;
				S_DCAP: state_q <= S_DSUB;
				S_DSUB: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// --------------------------------------------------------------------
	// gains, batch counter, history valid bits, output valid
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= '0;
			kd_q        <= '0;
			batch_cnt_q <= '0;
			out_vld_q   <= 1'b0;
			for (int i = 0; i < MOTORS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KP:  kp_q <= cfg_data;
					REG_KD:  kd_q <= cfg_data;
					default: ;
				endcase
			end
			// advance the batch after its last status
			if (s_acc && s_tlast) begin
				batch_cnt_q <= batch_cnt_q + 32'd1;
			end
			if (state_q == S_DIFF) begin
				vld_q[addr_q] <= 1'b1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// --------------------------------------------------------------------
	// history memory: read on accept, write back once the differences exist
	// --------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s_acc) begin
			prev_pos_q  <= pos_mem[in_addr];
			prev_tick_q <= tick_mem[in_addr];
		end
		if (state_q == S_DIFF) begin
			pos_mem[addr_q]  <= pnow_q;
			tick_mem[addr_q] <= ticks_q;
		end
	end

	// --------------------------------------------------------------------
	// differences and magnitudes
	// --------------------------------------------------------------------
	assign prev_pos  = prev_vld_q ? prev_pos_q  : '0;
	assign prev_tick = prev_vld_q ? prev_tick_q : '0;

	assign err_w  = {ptgt_q[Q_W-1], ptgt_q} - {pnow_q[Q_W-1], pnow_q};
	assign dpos_w = {pnow_q[Q_W-1], pnow_q} - {prev_pos[Q_W-1], prev_pos};
	assign dt_w   = ticks_q - prev_tick;

	assign err_abs  = err_w[Q_W]    ? (~err_w + 33'd1)  : err_w;
	assign dpos_abs = dpos_w[Q_W]   ? (~dpos_w + 33'd1) : dpos_w;
	assign dt_abs   = dt_w[Q_W-1]   ? (~dt_w + 32'd1)   : dt_w;

	// --------------------------------------------------------------------
	// shared multiplier operands
	// --------------------------------------------------------------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MULV: begin
				mul_a = dpos_mag_q;
				mul_b = TICK_RATE;
			end
			S_MULP: begin
				mul_a = err_mag_q;
				mul_b = kp_q;
			end
			S_MULL: begin
				mul_a = vel_q[Q_W-1:0];
				mul_b = kd_q;
			end
			S_MULH: begin
				mul_a = {4'b0000, vel_q[DVD_W-1:Q_W]};
				mul_b = kd_q;
			end
			default: ;
		endcase
	end

	// --------------------------------------------------------------------
	// velocity divider, started with |dpos| * TICK_RATE
	// --------------------------------------------------------------------
	assign div_req.start    = (state_q == S_MULP);
	assign div_req.dividend = prod_q[DVD_W-1:0];
	assign div_req.divisor  = dt_mag_q;

	mmpd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// --------------------------------------------------------------------
	// term assembly and saturation
	// --------------------------------------------------------------------
	assign ctgt_ext = {{32{ctgt_q[Q_W-1]}}, ctgt_q};
	assign p_ext    = {16'h0000, prod_q[63:16]};
	assign d_ext    = {3'b000, dmag_q};
	// kd product: high partial shifted up plus the low partial shifted down
	assign d_sum    = {1'b0, prod_q[43:0], 16'h0000} + {13'h0000, lo_q[63:16]};

	assign acc_fits = (acc_q[63:31] == '0) || (acc_q[63:31] == '1);
	assign cur_sat  = acc_fits ? acc_q[Q_W-1:0] : (acc_q[63] ? CUR_MIN : CUR_MAX);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		if (s_acc) begin
			idx_q      <= in_idx;
			addr_q     <= in_addr;
			ptgt_q     <= s_tdata[31:0];
			ctgt_q     <= s_tdata[63:32];
			pnow_q     <= s_tdata[95:64];
			ticks_q    <= s_tdata[127:96];
			batch_q    <= batch_cnt_q;
			prev_vld_q <= vld_q[in_addr];
			// settle the simple modes right here
			drive_q <= DRV_OPEN;
			acc_q   <= '0;
			if (in_rng) begin
				case (in_mode)
					MODE_BRAKE: drive_q <= DRV_BRAKE;
					MODE_CURRENT: begin
						drive_q <= DRV_CURRENT;
						acc_q   <= {{32{s_tdata[63]}}, s_tdata[63:32]};
					end
					MODE_POSITION: drive_q <= DRV_CURRENT;
					default: ;
				endcase
			end
		end

		case (state_q)
			S_DIFF: begin
				err_neg_q  <= err_w[Q_W];
				err_mag_q  <= err_abs[Q_W-1:0];
				dpos_mag_q <= dpos_abs[Q_W-1:0];
				dt_mag_q   <= dt_abs;
				dt_zero_q  <= (dt_w == '0);
				vel_neg_q  <= dpos_w[Q_W] ^ dt_w[Q_W-1];
			end
			S_PADD: begin
				acc_q <= err_neg_q ? (ctgt_ext - p_ext) : (ctgt_ext + p_ext);
			end
			S_DIV: begin
				// no elapsed ticks: no velocity
				vel_q <= dt_zero_q ? '0 : div_rsp.quotient;
			end
			S_MULH: begin
				lo_q <= prod_q;
			end
			S_DCAP: begin
				if (prod_q[63:44] != '0 || d_sum > D_CAP) begin
					dmag_q <= D_CAP;
				end else begin
					dmag_q <= d_sum;
				end
			end
			S_DSUB: begin
				acc_q <= vel_neg_q ? (acc_q + d_ext) : (acc_q - d_ext);
			end
			default: ;
		endcase

		if (out_load) begin
			out_idx_q   <= idx_q;
			out_batch_q <= batch_q;
			out_drive_q <= drive_q;
			out_cur_q   <= cur_sat;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_cur_q, out_batch_q};
	assign m_tuser  = {out_drive_q, out_idx_q};

endmodule

// File: hw/rtl/mmpd_checker.sv
// ----------------------------------------------------------------------------
// mmpd_checker
// Port-level checks of the multi-motor PD command block, bound to the top.
// ----------------------------------------------------------------------------
module mmpd_checker
	import mmpd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [4:0]  m_tuser
);

	// one request at a time: drop ready right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
	else $error("mmpd: s_tready stayed high after an accept");

	// a stalled command holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
	else $error("mmpd: stalled command changed");

	// open and brake commands carry no current
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[4:3] != DRV_CURRENT) |-> (m_tdata[63:32] == '0))
	else $error("mmpd: current on a non-current command");

	// no command can appear in the cycle right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
	else $error("mmpd: command appeared too early");

endmodule

bind multi_motor_pd_command mmpd_checker u_mmpd_checker (.*);

// File: tb/sv/tb_multi_motor_pd_command.sv
// ----------------------------------------------------------------------------
// tb_multi_motor_pd_command
// Self-checking bench for the multi-motor PD command block: a scoreboard keeps
// its own copy of the per-motor history, the gains and the batch counter, and
// compares every command with its prediction while both stream sides idle and
// stall at random.
// ----------------------------------------------------------------------------
import mmpd_pkg::*;

typedef struct packed {
	logic [IDX_W-1:0]  motor;
	logic [MODE_W-1:0] mode;
	logic [Q_W-1:0]    pos_target;
	logic [Q_W-1:0]    cur_target;
	logic [Q_W-1:0]    pos_now;
	logic [Q_W-1:0]    ticks;
	logic              last;
} motor_status_t;

typedef struct packed {
	logic [IDX_W-1:0]  motor;
	logic [Q_W-1:0]    batch;
	logic [MODE_W-1:0] drive;
	logic [Q_W-1:0]    current;
} drive_cmd_t;

localparam longint TICKS_PER_SEC = 64'sd180_000_000;
localparam longint DERIV_CAP     = 64'sh1000_0000_0000_0000;
localparam longint CUR_HI        = 64'sd2147483647;
localparam longint CUR_LO        = -64'sd2147483648;
localparam int     MAX_PRINTED   = 50;

class pd_command_scoreboard;
	logic [Q_W-1:0] kp;
	logic [Q_W-1:0] kd;
	logic [Q_W-1:0] last_pos[MOTORS_DEF];
	logic [Q_W-1:0] last_ticks[MOTORS_DEF];
	logic [Q_W-1:0] batch_count;
	drive_cmd_t     expected_cmds[$];
	int             errors;
	int             checked;

	function new();
		kp = '0;
		kd = '0;
		batch_count = '0;
		errors = 0;
		checked = 0;
		foreach (last_pos[i]) begin
			last_pos[i] = '0;
			last_ticks[i] = '0;
		end
	endfunction

	function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] value);
		case (idx)
		REG_KP: kp = value;
		REG_KD: kd = value;
		default: ;
		endcase
	endfunction

	function longint sx(logic [Q_W-1:0] v);
		return longint'($signed(v));
	endfunction

	function int pending();
		return expected_cmds.size();
	endfunction

	// One command per status; position requests also move that motor's history.
	function drive_cmd_t predict_command(motor_status_t s);
		drive_cmd_t   c;
		longint       err, dpos, dt, vel, p_term, d_term, sum;
		logic [63:0]  err_mag, dpos_mag, dt_mag, vel_mag;
		logic [127:0] prod;
		c.motor = s.motor;
		c.batch = batch_count;
		c.drive = DRV_OPEN;
		c.current = '0;
		case (s.mode)
		MODE_BRAKE: c.drive = DRV_BRAKE;
		MODE_CURRENT: begin
			c.drive = DRV_CURRENT;
			c.current = s.cur_target;
		end
		MODE_POSITION: begin
			err = sx(s.pos_target) - sx(s.pos_now);
			dpos = sx(s.pos_now) - sx(last_pos[s.motor]);
			dt = sx(s.ticks - last_ticks[s.motor]);
			err_mag = (err < 0) ? -err : err;
			dpos_mag = (dpos < 0) ? -dpos : dpos;
			vel = 0;
			// no elapsed ticks: treat as standing still
			if (dt != 0) begin
				dt_mag = (dt < 0) ? -dt : dt;
				vel_mag = dpos_mag * 64'(TICKS_PER_SEC) / dt_mag;
				vel = ((dpos < 0) != (dt < 0)) ? -longint'(vel_mag) : longint'(vel_mag);
			end
			vel_mag = (vel < 0) ? -vel : vel;
			prod = 128'(kp) * 128'(err_mag);
			p_term = longint'(prod[79:16]);
			if (err < 0)
				p_term = -p_term;
			prod = 128'(kd) * 128'(vel_mag);
			if ((prod >> 16) > 128'(DERIV_CAP))
				d_term = DERIV_CAP;
			else
				d_term = longint'(prod[79:16]);
			if (vel < 0)
				d_term = -d_term;
			sum = sx(s.cur_target) + p_term - d_term;
			if (sum > CUR_HI)
				sum = CUR_HI;
			if (sum < CUR_LO)
				sum = CUR_LO;
			c.drive = DRV_CURRENT;
			c.current = sum[31:0];
			last_pos[s.motor] = s.pos_now;
			last_ticks[s.motor] = s.ticks;
		end
		default: ;
		endcase
		if (s.last)
			batch_count = batch_count + 1'b1;
		return c;
	endfunction

	function void note_status(motor_status_t s);
		expected_cmds.push_back(predict_command(s));
	endfunction

	task report(string what);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("mismatch at command %0d: %s", checked, what);
	endtask

	task check_command(drive_cmd_t got);
		drive_cmd_t want;
		if (expected_cmds.size() == 0) begin
			report($sformatf("command with nothing pending, motor %0d", got.motor));
			return;
		end
		want = expected_cmds.pop_front();
		if (got.motor !== want.motor)
			report($sformatf("motor_number %0d, want %0d", got.motor, want.motor));
		if (got.batch !== want.batch)
			report($sformatf("batch_number %0d, want %0d", got.batch, want.batch));
		if (got.drive !== want.drive)
			report($sformatf("drive_mode %0d, want %0d", got.drive, want.drive));
		if (got.current !== want.current)
			report($sformatf("current_command %h, want %h", got.current, want.current));
		checked++;
	endtask
endclass

module tb_multi_motor_pd_command;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES   = 10;
	localparam int PHASE_ITEMS    = 270;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 100;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_KP;
	logic [Q_W-1:0]       cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [127:0]         s_tdata = '0;
	logic [4:0]           s_tuser = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [63:0]          m_tdata;
	logic [4:0]           m_tuser;

	// idle and stall odds in percent, changed per phase
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	logic hold_off = 1'b0;

	// plausible per-motor trajectories for the well-formed part of the stimulus
	logic [Q_W-1:0] track_pos[MOTORS_DEF];
	logic [Q_W-1:0] track_ticks[MOTORS_DEF];

	pd_command_scoreboard sb = new();

	multi_motor_pd_command uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	// Receiver: decide ready at the falling edge, stall at random or during a hold-off.
	always @(negedge clk) begin
		m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// Unpack every accepted command and hand it to the scoreboard.
	always @(posedge clk) begin : command_monitor
		drive_cmd_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.motor = m_tuser[IDX_W-1:0];
			got.drive = m_tuser[IDX_W +: MODE_W];
			got.batch = m_tdata[31:0];
			got.current = m_tdata[63:32];
			sb.check_command(got);
		end
	end

	// Watchdog: end the run when neither side moves a request for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// Offer one status; called and left at a falling edge.
	task automatic send_status(input logic [IDX_W-1:0] motor, input logic [MODE_W-1:0] mode,
			input logic [Q_W-1:0] pos_target, input logic [Q_W-1:0] cur_target,
			input logic [Q_W-1:0] pos_now, input logic [Q_W-1:0] ticks, input logic last);
		motor_status_t s;
		s.motor = motor;
		s.mode = mode;
		s.pos_target = pos_target;
		s.cur_target = cur_target;
		s.pos_now = pos_now;
		s.ticks = ticks;
		s.last = last;
		// drop valid for a random gap before the offer
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {ticks, pos_now, cur_target, pos_target};
		s_tuser <= {mode, motor};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_status(s);
		@(negedge clk);
	endtask

	// Mostly smooth moves with small steps; the rest is raw noise on every field.
	task automatic send_random_status();
		logic [IDX_W-1:0]  m;
		logic [MODE_W-1:0] md;
		logic [Q_W-1:0]    pt, ct, pn, tk;
		logic              lst;
		int                r;
		m = IDX_W'($urandom_range(MOTORS_DEF - 1));
		r = $urandom_range(99);
		md = (r < 55) ? MODE_POSITION : (r < 70) ? MODE_CURRENT :
			(r < 85) ? MODE_BRAKE : MODE_OPEN;
		lst = ($urandom_range(3) == 0);
		if ($urandom_range(99) < 80) begin
			// now and then repeat the timestamp to hit the zero-elapsed case
			if ($urandom_range(99) >= 3)
				track_ticks[m] = track_ticks[m] + $urandom_range(90, 360_000);
			track_pos[m] = track_pos[m] + $urandom_range(0, 'h8_0000) - 'h4_0000;
			pn = track_pos[m];
			tk = track_ticks[m];
			pt = pn + $urandom_range(0, 'h4_0000) - 'h2_0000;
			ct = $urandom_range(0, 'h2_0000) - 'h1_0000;
		end else begin
			pt = $urandom;
			ct = $urandom;
			pn = $urandom;
			tk = $urandom;
		end
		send_status(m, md, pt, ct, pn, tk, lst);
	endtask

	// Drop valid and hold until every command has come back.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Write both gains on back-to-back cycles while the block is idle.
	task automatic set_gains(input logic [Q_W-1:0] kp, input logic [Q_W-1:0] kd);
		cfg_we <= 1'b1;
		cfg_index <= REG_KP;
		cfg_data <= kp;
		@(negedge clk);
		cfg_index <= REG_KD;
		cfg_data <= kd;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_gain(REG_KP, kp);
		sb.set_gain(REG_KD, kd);
	endtask

	initial begin : stimulus
		int send_pct[4];
		int recv_pct[4];
		send_pct = '{0, 64, 0, 22};
		recv_pct = '{0, 0, 64, 22};
		foreach (track_pos[i]) begin
			track_pos[i] = $urandom;
			track_ticks[i] = $urandom;
		end

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// gains still at reset: first position request sees zero history
		send_status(0, MODE_POSITION, 32'h0001_0000, 32'h0000_1234, 32'h0000_8000, 32'd1000, 1'b0);
		send_status(7, MODE_OPEN, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b0);
		send_status(7, MODE_BRAKE, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b1);
		send_status(3, MODE_CURRENT, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
		send_status(3, MODE_CURRENT, 32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			1'b1);

		// unity kp: saturation both ways, zero and wrapped tick differences
		wait_idle();
		set_gains(32'h0001_0000, 32'h0000_0100);
		send_status(1, MODE_POSITION, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0);
		send_status(1, MODE_POSITION, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
			1'b0);
		send_status(1, MODE_POSITION, 32'h0, 32'h0, 32'h0001_8000, 32'hffff_ffff, 1'b1);
		send_status(2, MODE_POSITION, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h8000_0000, 1'b0);
		send_status(2, MODE_POSITION, 32'h0, 32'h0, 32'h0000_8000, 32'h7fff_ffff, 1'b0);
		send_status(4, MODE_POSITION, 32'h0005_0000, 32'h0000_2000, 32'h0000_1000, 32'd180_000,
			1'b0);
		send_status(4, MODE_POSITION, 32'h0005_0000, 32'hffff_e000, 32'h0000_3000, 32'd360_000,
			1'b1);

		// full-scale gains: derivative cap, then history kept across other modes
		wait_idle();
		set_gains(32'hffff_ffff, 32'hffff_ffff);
		send_status(5, MODE_POSITION, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'd1, 1'b0);
		send_status(5, MODE_POSITION, 32'h7fff_ffff, 32'h0000_4000, 32'h7fff_ffff, 32'd2, 1'b0);
		send_status(6, MODE_POSITION, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 1'b0);
		send_status(6, MODE_CURRENT, 32'h0, 32'hffff_0000, 32'h7fff_ffff, 32'h1234_5678, 1'b0);
		send_status(6, MODE_POSITION, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0000_0010, 1'b0);
		send_status(0, MODE_OPEN, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
		send_status(0, MODE_BRAKE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			1'b0);

		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			case (ph)
			0: set_gains($urandom_range('h8000, 'h4_0000), $urandom_range(0, 'h400));
			1: set_gains(32'hffff_ffff, 32'h0);
			2: set_gains(32'h0, 32'hffff_ffff);
			default: set_gains($urandom, $urandom);
			endcase
			send_idle_pct = send_pct[ph];
			recv_stall_pct = recv_pct[ph];
			// first phase: hold the receiver off for a long stretch so the block backs up
			if (ph == 0) begin
				fork
					begin
						@(posedge clk);
						hold_off = 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			repeat (PHASE_ITEMS) send_random_status();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/mmpd_pkg.sv
hw/rtl/mmpd_divider.sv
hw/rtl/multi_motor_pd_command.sv
hw/rtl/mmpd_checker.sv
tb/sv/tb_multi_motor_pd_command.sv
